FILE: src/bsnp_pkg.sv
// Package for the bounded stack with negative purge.
// Holds the request codes, widths, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package bsnp_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 64;
	localparam int unsigned DATA_W          = 32;
	localparam int unsigned LEVEL_W         = 7;
	localparam int unsigned REQ_W           = 2;

	localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_PURGE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP_RD,
		ST_POP_FIN,
		ST_SCAN,
		ST_PURGE_FIN
	} state_t;

	typedef struct packed {
		logic load;       // latch a new request, clear the scan counters
		logic exec_push;  // commit a push (or a no-op) and load the result
		logic rd_pop;     // read address selects the word below the top
		logic pop_fin;    // commit a pop and load the result
		logic scan;       // run one step of the purge compaction
		logic purge_fin;  // commit the purge and load the result
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
	} dp_stat_t;

endpackage

FILE: src/bounded_stack_with_negative_purge.sv
// Top level of the bounded stack with negative purge.
// Depends on bsnp_pkg, bsnp_ctrl and bsnp_dpath (which holds the bsnp_ram store).
//
// Channel | Handshake            | Payload
// --------+----------------------+--------------------------------------------------
// in      | in_valid / in_stall  | req_type, push_value
// out     | out_valid / out_stall| popped_value, popped_valid, top_value, top_valid,
//         |                      | rejected, level, is_empty, is_full
//
// One request is in work at a time. Push or no-op completes from the execute state; pop
// first reads the word below the top through the store's registered read port. Purge
// runs the compaction scan, one stored word read per cycle.
// arst_n clears the level to empty; the store itself is not cleared.
// A finished result waits in the output register under out_stall; the next request is
// taken meanwhile and completes once the register drains.
`timescale 1ns / 1ps

module bounded_stack_with_negative_purge #(
	parameter int unsigned STACK_DEPTH = bsnp_pkg::STACK_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [bsnp_pkg::REQ_W-1:0]         req_type,
	input  logic signed [bsnp_pkg::DATA_W-1:0] push_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [bsnp_pkg::DATA_W-1:0] popped_value,
	output logic                               popped_valid,
	output logic signed [bsnp_pkg::DATA_W-1:0] top_value,
	output logic                               top_valid,
	output logic                               rejected,
	output logic [bsnp_pkg::LEVEL_W-1:0]       level,
	output logic                               is_empty,
	output logic                               is_full
);
	import bsnp_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bsnp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	bsnp_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (req_type),
		.push_value   (push_value),
		.popped_value (popped_value),
		.popped_valid (popped_valid),
		.top_value    (top_value),
		.top_valid    (top_valid),
		.rejected     (rejected),
		.level        (level),
		.is_empty     (is_empty),
		.is_full      (is_full)
	);

endmodule

FILE: src/bsnp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bsnp_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/bsnp_ctrl.sv
// Controller state machine for the bounded stack with negative purge.
// Depends on bsnp_pkg; drives the datapath through dp_cmd_t and owns the handshakes.
`timescale 1ns / 1ps

module bsnp_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [bsnp_pkg::REQ_W-1:0] req_type,
	output logic                       out_valid,
	input  logic                       out_stall,
	input  bsnp_pkg::dp_stat_t         stat,
	output bsnp_pkg::dp_cmd_t          cmd
);
	import bsnp_pkg::*;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   slot_free;
	logic   accept;
	logic   load_result;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_POP:   state_n = ST_POP_RD;
						REQ_PURGE: state_n = ST_SCAN;
						default:   state_n = ST_EXEC;
					endcase
				end
			end
			ST_EXEC: begin
				if (slot_free) state_n = ST_IDLE;
			end
			ST_POP_RD: begin
				state_n = ST_POP_FIN;
			end
			ST_POP_FIN: begin
				if (slot_free) state_n = ST_IDLE;
			end
			ST_SCAN: begin
				if (stat.scan_done) state_n = ST_PURGE_FIN;
			end
			ST_PURGE_FIN: begin
				if (slot_free) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:      cmd.load      = accept;
			ST_EXEC:      cmd.exec_push = slot_free;
			ST_POP_RD:    cmd.rd_pop    = 1'b1;
			ST_POP_FIN: begin
				cmd.rd_pop  = 1'b1;
				cmd.pop_fin = slot_free;
			end
			ST_SCAN:      cmd.scan      = 1'b1;
			ST_PURGE_FIN: cmd.purge_fin = slot_free;
			default:      cmd = '0;
		endcase
	end

	assign load_result = cmd.exec_push || cmd.pop_fin || cmd.purge_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			// a new result wins over the transaction that drains the old one
			if (load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/bsnp_dpath.sv
// Datapath for the bounded stack with negative purge: store, level, top and result register.
// Depends on bsnp_pkg and bsnp_ram; driven by bsnp_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module bsnp_dpath #(
	parameter int unsigned STACK_DEPTH = bsnp_pkg::STACK_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bsnp_pkg::dp_cmd_t                  cmd,
	output bsnp_pkg::dp_stat_t                 stat,
	input  logic [bsnp_pkg::REQ_W-1:0]         req_type,
	input  logic signed [bsnp_pkg::DATA_W-1:0] push_value,
	output logic signed [bsnp_pkg::DATA_W-1:0] popped_value,
	output logic                               popped_valid,
	output logic signed [bsnp_pkg::DATA_W-1:0] top_value,
	output logic                               top_valid,
	output logic                               rejected,
	output logic [bsnp_pkg::LEVEL_W-1:0]       level,
	output logic                               is_empty,
	output logic                               is_full
);
	import bsnp_pkg::*;

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
	localparam logic [LW-1:0] LVL_MAX = LW'(STACK_DEPTH);

	logic [REQ_W-1:0]  req_q;
	logic [DATA_W-1:0] val_q;
	logic [LW-1:0]     level_q;
	logic [DATA_W-1:0] top_q;
	logic [LW-1:0]     rd_q;
	logic [LW-1:0]     wr_q;
	logic              pend_q;
	logic [DATA_W-1:0] scan_top_q;

	logic [DATA_W-1:0] res_popped_q;
	logic              res_pv_q;
	logic [DATA_W-1:0] res_top_q;
	logic              res_tv_q;
	logic              res_rej_q;
	logic [LW-1:0]     res_level_q;
	logic              res_empty_q;
	logic              res_full_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic [LW-1:0]     pop_addr;

	logic              issue;
	logic              keep;
	logic              push_we;
	logic              commit;
	logic [LW-1:0]     lvl_n;
	logic [DATA_W-1:0] top_n;
	logic [DATA_W-1:0] popped_n;
	logic              pv_n;
	logic              rej_n;
	logic [LW+LEVEL_W-1:0] lvl_ext;

	bsnp_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// compaction: read at rd_q, write kept words back at wr_q, which never passes rd_q
	assign issue = cmd.scan && (rd_q != level_q);
	assign keep  = cmd.scan && pend_q && !ram_rdata[DATA_W-1];
	assign stat.scan_done = (rd_q == level_q) && !pend_q;

	assign push_we   = cmd.exec_push && (req_q == REQ_PUSH) && (level_q != LVL_MAX);
	assign pop_addr  = level_q - LW'(2);
	assign ram_we    = push_we || keep;
	assign ram_waddr = keep ? wr_q[AW-1:0] : level_q[AW-1:0];
	assign ram_wdata = keep ? ram_rdata : val_q;
	assign ram_raddr = cmd.rd_pop ? pop_addr[AW-1:0] : rd_q[AW-1:0];

	assign commit = cmd.exec_push || cmd.pop_fin || cmd.purge_fin;

	always_comb begin
		lvl_n    = level_q;
		top_n    = top_q;
		popped_n = '0;
		pv_n     = 1'b0;
		rej_n    = 1'b0;
		priority if (cmd.exec_push) begin
			if (req_q == REQ_PUSH) begin
				if (level_q == LVL_MAX) begin
					rej_n = 1'b1;
				end else begin
					lvl_n = level_q + LW'(1);
					top_n = val_q;
				end
			end
		end else if (cmd.pop_fin) begin
			if (level_q == '0) begin
				rej_n = 1'b1;
			end else begin
				lvl_n    = level_q - LW'(1);
				popped_n = top_q;
				pv_n     = 1'b1;
				top_n    = (level_q > LW'(1)) ? ram_rdata : '0;
			end
		end else if (cmd.purge_fin) begin
			lvl_n = wr_q;
			top_n = (wr_q != '0) ? scan_top_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			top_q   <= '0;
			pend_q  <= 1'b0;
			rd_q    <= '0;
			wr_q    <= '0;
		end else begin
			pend_q <= issue;
			if (cmd.load) begin
				rd_q <= '0;
				wr_q <= '0;
			end else begin
				if (issue) rd_q <= rd_q + LW'(1);
				if (keep)  wr_q <= wr_q + LW'(1);
			end
			if (commit) begin
				level_q <= lvl_n;
				top_q   <= top_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			val_q <= push_value;
		end
		if (keep) begin
			scan_top_q <= ram_rdata;
		end
		if (commit) begin
			res_popped_q <= popped_n;
			res_pv_q     <= pv_n;
			res_top_q    <= top_n;
			res_tv_q     <= (lvl_n != '0);
			res_rej_q    <= rej_n;
			res_level_q  <= lvl_n;
			res_empty_q  <= (lvl_n == '0);
			res_full_q   <= (lvl_n == LVL_MAX);
		end
	end

	assign lvl_ext      = {{LEVEL_W{1'b0}}, res_level_q};
	assign level        = lvl_ext[LEVEL_W-1:0];
	assign popped_value = res_popped_q;
	assign popped_valid = res_pv_q;
	assign top_value    = res_top_q;
	assign top_valid    = res_tv_q;
	assign rejected     = res_rej_q;
	assign is_empty     = res_empty_q;
	assign is_full      = res_full_q;

endmodule

FILE: src/bsnp_checker.sv
// Port-level checker for the bounded stack with negative purge, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module bsnp_port_checks (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       popped_valid,
	input logic       top_valid,
	input logic       rejected,
	input logic [6:0] level,
	input logic       is_empty,
	input logic       is_full
);

	// one request in work at a time: intake closes right after a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a request is in work");

	a_top_vs_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (top_valid == !is_empty) && (is_empty == (level == 7'd0)))
		else $error("top_valid, is_empty and level disagree");

	a_pop_not_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && popped_valid |-> !rejected && !is_full)
		else $error("successful pop flagged rejected or full");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(level) && $stable(popped_valid))
		else $error("stalled result changed");

endmodule

bind bounded_stack_with_negative_purge bsnp_port_checks u_bsnp_port_checks (.*);

FILE: sim/bsnp_checker.sv
// Checker for the bounded stack with negative purge: watches both channels and predicts results.
// Depends on bsnp_pkg for widths and request codes; reports a failure count and pending depth.
`timescale 1ns / 1ps

module bsnp_checker #(
	parameter int unsigned STACK_DEPTH = bsnp_pkg::STACK_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [bsnp_pkg::REQ_W-1:0]         req_type,
	input  logic signed [bsnp_pkg::DATA_W-1:0] push_value,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic signed [bsnp_pkg::DATA_W-1:0] popped_value,
	input  logic                               popped_valid,
	input  logic signed [bsnp_pkg::DATA_W-1:0] top_value,
	input  logic                               top_valid,
	input  logic                               rejected,
	input  logic [bsnp_pkg::LEVEL_W-1:0]       level,
	input  logic                               is_empty,
	input  logic                               is_full,
	output int unsigned                        fail_count,
	output int unsigned                        pending
);
	import bsnp_pkg::*;

	localparam int unsigned MAX_REPORTS = 10;

	typedef struct packed {
		logic signed [DATA_W-1:0] popped_value;
		logic                     popped_valid;
		logic signed [DATA_W-1:0] top_value;
		logic                     top_valid;
		logic                     rejected;
		logic [LEVEL_W-1:0]       level;
		logic                     is_empty;
		logic                     is_full;
	} stack_status_t;

	logic signed [DATA_W-1:0] words [STACK_DEPTH];
	int unsigned              held = 0;
	stack_status_t            expected_status [$];
	stack_status_t            seen;
	stack_status_t            want;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// Apply one request to the shadow stack and return the status it should produce.
	function automatic stack_status_t stack_apply(input logic [REQ_W-1:0] req,
			input logic signed [DATA_W-1:0] val);
		stack_status_t r;
		int unsigned   keep;
		r = '0;
		case (req)
			REQ_PUSH: begin
				if (held < STACK_DEPTH) begin
					words[held] = val;
					held++;
				end else begin
					r.rejected = 1'b1;
				end
			end
			REQ_POP: begin
				if (held > 0) begin
					held--;
					r.popped_value = words[held];
					r.popped_valid = 1'b1;
				end else begin
					r.rejected = 1'b1;
				end
			end
			REQ_PURGE: begin
				// compact non-negative words toward the bottom, order kept
				keep = 0;
				for (int i = 0; i < held; i++) begin
					if (!words[i][DATA_W-1]) begin
						words[keep] = words[i];
						keep++;
					end
				end
				held = keep;
			end
			default: begin
			end
		endcase
		if (held > 0) begin
			r.top_value = words[held-1];
			r.top_valid = 1'b1;
		end
		r.level = held[LEVEL_W-1:0];
		r.is_empty = (held == 0);
		r.is_full = (held == STACK_DEPTH);
		return r;
	endfunction

	function automatic string status_text(input stack_status_t s);
		return $sformatf("pop=%0d/%0b top=%0d/%0b rej=%0b lvl=%0d empty=%0b full=%0b",
			s.popped_value, s.popped_valid, s.top_value, s.top_valid, s.rejected,
			s.level, s.is_empty, s.is_full);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_status.push_back(stack_apply(req_type, push_value));
			if (out_valid && !out_stall) begin
				seen = '{popped_value, popped_valid, top_value, top_valid, rejected, level,
					is_empty, is_full};
				if (expected_status.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: result with no request pending: %s", $realtime,
							status_text(seen));
				end else begin
					want = expected_status.pop_front();
					if (seen !== want) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$display("%0t: expected %s", $realtime, status_text(want));
							$display("%0t: actual   %s", $realtime, status_text(seen));
						end
					end
				end
			end
			pending = expected_status.size();
		end
	end

endmodule

FILE: sim/tb_bounded_stack_with_negative_purge.sv
// Testbench top for the bounded stack with negative purge: clock, reset, stimulus and verdict.
// Depends on bsnp_pkg, the block under test and bsnp_checker, which checks every result.
`timescale 1ns / 1ps

module tb_bounded_stack_with_negative_purge;
	import bsnp_pkg::*;

	localparam int unsigned DEPTH        = STACK_DEPTH_DEF;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1300;
	localparam int HOLD_CYCLES  = 300;
	localparam int STUCK_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 80;
	localparam int FILL_ITEMS   = 150;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_CHURN} mix_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [REQ_W-1:0]          req_type;
	logic signed [DATA_W-1:0]  push_value;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [DATA_W-1:0]  popped_value;
	logic                      popped_valid;
	logic signed [DATA_W-1:0]  top_value;
	logic                      top_valid;
	logic                      rejected;
	logic [LEVEL_W-1:0]        level;
	logic                      is_empty;
	logic                      is_full;
	int unsigned               fail_count;
	int unsigned               pending;

	int tx_idle_pct = 35;
	int rx_idle_pct = 83;
	int phase = 0;
	int stuck_cycles = 0;

	bounded_stack_with_negative_purge #(.STACK_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .push_value(push_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.popped_value(popped_value), .popped_valid(popped_valid),
		.top_value(top_value), .top_valid(top_valid),
		.rejected(rejected), .level(level), .is_empty(is_empty), .is_full(is_full)
	);

	bsnp_checker #(.STACK_DEPTH(DEPTH)) stack_watch (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .push_value(push_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.popped_value(popped_value), .popped_valid(popped_valid),
		.top_value(top_value), .top_valid(top_valid),
		.rejected(rejected), .level(level), .is_empty(is_empty), .is_full(is_full),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver: random stall, plus one long hold-off when the last phase begins.
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (phase == 2 && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	// Watchdog: end the run if no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [REQ_W-1:0] req,
			input logic signed [DATA_W-1:0] val);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		push_value <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_word();
		case ($urandom_range(7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -1;
			4: return $urandom_range(100);
			5: return -$signed({1'b0, 31'($urandom_range(100))});
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [REQ_W-1:0] pick_request(input int push_pct, input int pop_pct,
			input int purge_pct);
		int r;
		r = $urandom_range(99);
		if (r < push_pct)
			return REQ_PUSH;
		else if (r < push_pct + pop_pct)
			return REQ_POP;
		else if (r < push_pct + pop_pct + purge_pct)
			return REQ_PURGE;
		else
			return REQ_UNUSED;
	endfunction

	initial begin
		int   sent;
		int   seg_left;
		int   p;
		int   push_pct;
		int   pop_pct;
		int   purge_pct;
		mix_t kind;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_PUSH;
		push_value = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-stack rejects, extremes, unused code, purges of each shape
		send_request(REQ_POP, pick_word());
		send_request(REQ_PURGE, pick_word());
		send_request(REQ_UNUSED, pick_word());
		send_request(REQ_PUSH, 32'sh8000_0000);
		send_request(REQ_PUSH, 32'sh7fff_ffff);
		send_request(REQ_PUSH, '0);
		send_request(REQ_PUSH, -1);
		send_request(REQ_UNUSED, pick_word());
		send_request(REQ_PUSH, 1);
		send_request(REQ_POP, pick_word());
		send_request(REQ_PURGE, pick_word());
		send_request(REQ_POP, pick_word());
		send_request(REQ_POP, pick_word());
		send_request(REQ_POP, pick_word());
		send_request(REQ_PUSH, -5);
		send_request(REQ_PUSH, -7);
		send_request(REQ_PURGE, pick_word());
		send_request(REQ_PUSH, 12345);
		send_request(REQ_PUSH, 32'sh5555_5555);
		send_request(REQ_PUSH, 32'shAAAA_AAAA);
		send_request(REQ_PURGE, pick_word());
		send_request(REQ_POP, pick_word());
		send_request(REQ_POP, pick_word());

		sent = 0;
		seg_left = 0;
		push_pct = 0;
		pop_pct = 0;
		purge_pct = 0;
		while (sent < RANDOM_ITEMS) begin
			p = sent * 3 / RANDOM_ITEMS;
			if (sent == 0 || p != phase) begin
				phase = p;
				case (phase)
					0: begin
						tx_idle_pct = 35;
						rx_idle_pct = 83;
					end
					1: begin
						tx_idle_pct = 83;
						rx_idle_pct = 35;
					end
					default: begin
						tx_idle_pct = 0;
						rx_idle_pct = 0;
					end
				endcase
				// open each phase by filling past full, no purge to slow it
				seg_left = FILL_ITEMS;
				push_pct = 85;
				pop_pct = 10;
				purge_pct = 0;
			end else if (seg_left == 0) begin
				kind = mix_t'($urandom_range(2));
				seg_left = $urandom_range(20, 120);
				case (kind)
					MIX_FILL: begin
						push_pct = 80;
						pop_pct = 12;
						purge_pct = 4;
					end
					MIX_DRAIN: begin
						push_pct = 15;
						pop_pct = 78;
						purge_pct = 4;
					end
					default: begin
						push_pct = 45;
						pop_pct = 40;
						purge_pct = 10;
					end
				endcase
			end
			send_request(pick_request(push_pct, pop_pct, purge_pct), pick_word());
			seg_left--;
			sent++;
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		// a result still owed after the drain counts as a mismatch
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
